>>> hw/rtl/bmp_rle_pixel_decoder_macros.svh
// ----------------------------------------------------------------------------
// BMP RLE pixel decoder assertion macros
// Shared concurrent assertion forms, clocked on clock, off during reset.
// ----------------------------------------------------------------------------
`ifndef BMP_RLE_PIXEL_DECODER_MACROS_SVH
`define BMP_RLE_PIXEL_DECODER_MACROS_SVH

// Same-cycle implication.
`define BMPRLE_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication checked in the cycle after the antecedent.
`define BMPRLE_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/bmprle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP RLE decoder package
// Shared types, codes and helpers for the front parser, queue and back end.
// ----------------------------------------------------------------------------
package bmprle_pkg;

   localparam int MAX_DIMENSION_DEF = 4096;
   localparam int DIM_LIMIT_W       = 17;
   localparam logic [12:0] CUR_MAX  = 13'h1FFF;
   localparam int QUEUE_DEPTH       = 2;

   typedef enum logic [1:0] {
      CSR_PIXEL_FORMAT = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_RUN,
      CMD_EOL,
      CMD_EOB,
      CMD_DELTA
   } cmd_op_type;

   // Command from the parser to the cursor/emit stage.
   // For CMD_DELTA, count carries dx and delta_row carries dy.
   typedef struct packed {
      cmd_op_type  op;
      logic        clear;
      logic [7:0]  count;
      logic [7:0]  value;
      logic [3:0]  value_lo;
      logic        alt;
      logic [7:0]  delta_row;
   } cmd_type;

   typedef struct packed {
      logic [11:0] row;
      logic [11:0] column;
      logic [7:0]  run_length;
      logic [7:0]  first_pixel;
      logic [3:0]  second_pixel;
      logic        alternate;
      logic        end_of_bitmap;
   } result_type;

   function automatic logic [12:0] clamp_dim(input logic [12:0] v,
                                             input logic [DIM_LIMIT_W-1:0] limit);
      logic [DIM_LIMIT_W-1:0] v_ext;
      v_ext = DIM_LIMIT_W'(v);
      return (v_ext > limit) ? limit[12:0] : v;
   endfunction

   function automatic logic [12:0] sat_add(input logic [12:0] a, input logic [12:0] b);
      logic [13:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[13] ? CUR_MAX : s[12:0];
   endfunction

endpackage

>>> hw/rtl/bmp_rle_pixel_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP RLE8/RLE4 pixel decoder
// Takes one compressed byte per transfer and gives clipped pixel-run
// descriptors; end-of-bitmap comes out as a run of length 0 with tlast set.
// Sustains one byte per clock while the queue has room: the parser classifies a
// byte in the cycle it is taken, a two-entry command queue carries it to the
// cursor stage, and that stage registers any result when it takes the command.
// A stalled output backs up only through the queue, so two command-carrying
// bytes are absorbed before req_tready falls. Width and height are clamped to
// MAX_DIMENSION. Pixel format applies on the next byte, width and height on the
// next command taken; configuration should be written while the stream is quiet.
// ----------------------------------------------------------------------------
`include "bmp_rle_pixel_decoder_macros.svh"

module bmp_rle_pixel_decoder
   import bmprle_pkg::*;
#(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // compressed stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] stream_byte
   input  logic        req_tuser,   // [0] start_of_image
   // pixel runs
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [11:0] row, [23:12] column, [31:24] run_length,
                                    // [39:32] first_pixel, [43:40] second_pixel,
                                    // [44] alternate, [47:45] zero
   output logic        rsp_tlast,   // end_of_bitmap
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [12:0] csr_data
);

   logic        pixel_format_ff;
   logic [12:0] image_width_ff, image_height_ff;
   logic [12:0] width_eff, height_eff;

   logic        fq_valid, fq_ready, qb_valid, qb_ready;
   cmd_type     fq_cmd, qb_cmd;
   result_type  result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= 1'b0;
         image_width_ff  <= 13'd1;
         image_height_ff <= 13'd1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_PIXEL_FORMAT: pixel_format_ff <= csr_data[0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_data;
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   bmprle_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_tvalid),
      .req_ready      (req_tready),
      .stream_byte    (req_tdata),
      .start_of_image (req_tuser),
      .rle4           (pixel_format_ff),
      .cmd_valid      (fq_valid),
      .cmd_ready      (fq_ready),
      .cmd            (fq_cmd)
   );

   bmprle_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_cmd   (fq_cmd),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_cmd    (qb_cmd)
   );

   bmprle_back #(
      .MAX_DIMENSION (MAX_DIMENSION)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cmd_valid    (qb_valid),
      .cmd_ready    (qb_ready),
      .cmd          (qb_cmd),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_result   (result)
   );

   assign rsp_tdata = {3'b000, result.alternate, result.second_pixel, result.first_pixel,
                       result.run_length, result.column, result.row};
   assign rsp_tlast = result.end_of_bitmap;

   assign width_eff  = clamp_dim(image_width_ff, DIM_LIMIT_W'(MAX_DIMENSION));
   assign height_eff = clamp_dim(image_height_ff, DIM_LIMIT_W'(MAX_DIMENSION));

   `BMPRLE_ASSERT_IMPL(a_run_nonzero, rsp_tvalid && !rsp_tlast, rsp_tdata[31:24] != 8'd0, "run of zero pixels emitted")
   `BMPRLE_ASSERT_IMPL(a_eob_empty, rsp_tvalid && rsp_tlast, (rsp_tdata[31:24] == 8'd0) && (rsp_tdata[44] == 1'b0), "end marker carries pixel data")
   `BMPRLE_ASSERT_IMPL(a_run_in_width, rsp_tvalid && !rsp_tlast, ({1'b0, rsp_tdata[23:12]} + {5'd0, rsp_tdata[31:24]}) <= width_eff, "run crosses image width")
   `BMPRLE_ASSERT_IMPL(a_row_in_height, rsp_tvalid && !rsp_tlast, {1'b0, rsp_tdata[11:0]} < height_eff, "run written past image height")

endmodule

>>> hw/rtl/bmprle_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP RLE front parser
// Walks the compressed byte stream and turns it into run/escape commands.
// ----------------------------------------------------------------------------
module bmprle_front
   import bmprle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  logic [7:0] stream_byte,
   input  logic    start_of_image,
   input  logic    rle4,
   output logic    cmd_valid,
   input  logic    cmd_ready,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      PH_COUNT,
      PH_VALUE,
      PH_ESCAPE,
      PH_DX,
      PH_DY,
      PH_ABS,
      PH_PAD
   } phase_type;

   phase_type  phase_ff, phase_in, cur_phase;
   logic       finished_ff, finished_in;
   logic [7:0] pending_ff, pending_in;
   logic [7:0] remain_ff, remain_in;
   logic       pad_ff, pad_in;
   logic [7:0] delta_ff, delta_in;
   logic [7:0] abs_n;
   logic       accept;

   assign req_ready = cmd_ready;
   assign accept    = req_valid && cmd_ready;

   always_comb begin
      phase_in    = phase_ff;
      finished_in = start_of_image ? 1'b0 : finished_ff;
      pending_in  = pending_ff;
      remain_in   = remain_ff;
      pad_in      = pad_ff;
      delta_in    = delta_ff;
      cur_phase   = start_of_image ? PH_COUNT : phase_ff;
      abs_n       = 8'd1;

      cmd           = '0;
      cmd.op        = CMD_NONE;
      cmd.clear     = start_of_image;
      cmd.value     = rle4 ? {4'b0000, stream_byte[7:4]} : stream_byte;
      cmd.value_lo  = rle4 ? stream_byte[3:0] : 4'd0;
      cmd.alt       = rle4;

      if (!finished_in) begin
         case (cur_phase)
            PH_COUNT: begin
               if (stream_byte != 8'd0) begin
                  pending_in = stream_byte;
                  phase_in   = PH_VALUE;
               end else begin
                  phase_in = PH_ESCAPE;
               end
            end
            PH_VALUE: begin
               cmd.op    = CMD_RUN;
               cmd.count = pending_ff;
               phase_in  = PH_COUNT;
            end
            PH_ESCAPE: begin
               if (stream_byte == 8'd0) begin
                  cmd.op   = CMD_EOL;
                  phase_in = PH_COUNT;
               end else if (stream_byte == 8'd1) begin
                  cmd.op      = CMD_EOB;
                  finished_in = 1'b1;
                  phase_in    = PH_COUNT;
               end else if (stream_byte == 8'd2) begin
                  phase_in = PH_DX;
               end else begin
                  remain_in  = stream_byte;
                  pending_in = stream_byte;
                  // RLE4 pads on an odd byte count, RLE8 on an odd pixel count
                  pad_in     = rle4 ? (stream_byte[1] ^ stream_byte[0]) : stream_byte[0];
                  phase_in   = PH_ABS;
               end
            end
            PH_DX: begin
               delta_in = stream_byte;
               phase_in = PH_DY;
            end
            PH_DY: begin
               cmd.op        = CMD_DELTA;
               cmd.count     = delta_ff;
               cmd.delta_row = stream_byte;
               phase_in      = PH_COUNT;
            end
            PH_ABS: begin
               if (rle4) begin
                  abs_n     = (remain_ff < 8'd2) ? remain_ff : 8'd2;
                  remain_in = remain_ff - abs_n;
               end else begin
                  abs_n     = 8'd1;
                  remain_in = remain_ff - {7'd0, remain_ff != 8'd0};
               end
               cmd.op    = CMD_RUN;
               cmd.count = abs_n;
               if (remain_in == 8'd0) begin
                  phase_in = pad_ff ? PH_PAD : PH_COUNT;
               end
            end
            default: begin
               pad_in   = 1'b0;
               phase_in = PH_COUNT;
            end
         endcase
      end

      cmd_valid = req_valid && ((cmd.op != CMD_NONE) || start_of_image);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_COUNT;
         finished_ff <= 1'b0;
         pending_ff  <= 8'd0;
         remain_ff   <= 8'd0;
         pad_ff      <= 1'b0;
         delta_ff    <= 8'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         finished_ff <= finished_in;
         pending_ff  <= pending_in;
         remain_ff   <= remain_in;
         pad_ff      <= pad_in;
         delta_ff    <= delta_in;
      end
   end

endmodule

>>> hw/rtl/bmprle_cmd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP RLE command queue
// Small FIFO between the parser and the cursor/emit stage.
// ----------------------------------------------------------------------------
module bmprle_cmd_queue
   import bmprle_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> hw/rtl/bmprle_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// BMP RLE cursor and emit stage
// Applies commands to the cursor, clips runs and registers the result.
// ----------------------------------------------------------------------------
module bmprle_back
   import bmprle_pkg::*;
#(
   parameter int MAX_DIMENSION = MAX_DIMENSION_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        cmd_valid,
   output logic        cmd_ready,
   input  cmd_type     cmd,
   input  logic [12:0] image_width,
   input  logic [12:0] image_height,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp_result
);

   logic        take;
   logic [12:0] row_ff, row_in, col_ff, col_in;
   logic [12:0] row_base, col_base;
   logic [12:0] width_eff, height_eff, room;
   logic [7:0]  run_len;
   logic        emit;
   logic        rsp_valid_ff, rsp_valid_in;
   result_type  result_ff, result_in, result_new;

   assign cmd_ready  = !rsp_valid_ff || rsp_ready;
   assign take       = cmd_valid && cmd_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = result_ff;

   always_comb begin
      row_base   = cmd.clear ? 13'd0 : row_ff;
      col_base   = cmd.clear ? 13'd0 : col_ff;
      width_eff  = clamp_dim(image_width, DIM_LIMIT_W'(MAX_DIMENSION));
      height_eff = clamp_dim(image_height, DIM_LIMIT_W'(MAX_DIMENSION));
      room       = width_eff - col_base;
      run_len    = 8'd0;
      if (col_base < width_eff) begin
         run_len = ({5'd0, cmd.count} < room) ? cmd.count : room[7:0];
      end

      row_in     = row_base;
      col_in     = col_base;
      emit       = 1'b0;
      result_new = '0;
      result_new.row    = row_base[11:0];
      result_new.column = col_base[11:0];

      case (cmd.op)
         CMD_RUN: begin
            emit = (run_len != 8'd0) && (row_base < height_eff);
            result_new.run_length   = run_len;
            result_new.first_pixel  = cmd.value;
            result_new.second_pixel = cmd.value_lo;
            result_new.alternate    = cmd.alt;
            // never passes the width, so no saturation needed here
            col_in = col_base + {5'd0, run_len};
         end
         CMD_EOL: begin
            row_in = sat_add(row_base, 13'd1);
            col_in = 13'd0;
         end
         CMD_EOB: begin
            emit = 1'b1;
            result_new.end_of_bitmap = 1'b1;
         end
         CMD_DELTA: begin
            col_in = sat_add(col_base, {5'd0, cmd.count});
            row_in = sat_add(row_base, {5'd0, cmd.delta_row});
         end
         default: begin
         end
      endcase

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      result_in    = result_ff;
      if (take) begin
         rsp_valid_in = emit;
         if (emit) begin
            result_in = result_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff       <= 13'd0;
         col_ff       <= 13'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

endmodule
